[sv/hlx_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hlx_pkg
// Shared types, register indexes and step tables of the Helix cipher core.
// ----------------------------------------------------------------------------
package hlx_pkg;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_KLOAD,
      S_RUN,
      S_NEXT,
      S_NLOAD,
      S_PREP0,
      S_PREP1,
      S_EMIT,
      S_WORD,
      S_TAIL
   } state_type;

   // kind of block being run
   typedef enum logic [2:0] {
      PH_KEY,
      PH_INIT,
      PH_DATA,
      PH_FIN,
      PH_TAG
   } phase_type;

   // register indexes
   localparam logic [2:0] CSR_KEY01  = 3'd0;
   localparam logic [2:0] CSR_KEY23  = 3'd1;
   localparam logic [2:0] CSR_KEY45  = 3'd2;
   localparam logic [2:0] CSR_KEY67  = 3'd3;
   localparam logic [2:0] CSR_KEYLEN = 3'd4;
   localparam logic [2:0] CSR_NONCEL = 3'd5;
   localparam logic [2:0] CSR_NONCEH = 3'd6;
   localparam logic [2:0] CSR_MODE   = 3'd7;

   localparam logic [31:0] MAC_TWEAK   = 32'h912d94f1;
   localparam logic [5:0]  KEY_LEN_MAX = 6'd32;
   localparam logic [31:0] KEY_E_BIAS  = 32'd64;
   localparam logic [4:0]  STEP_LAST   = 5'd19;
   localparam logic [4:0]  STEP_HALF   = 5'd10;
   localparam logic [2:0]  BLK_EIGHT   = 3'd7;
   localparam logic [2:0]  BLK_FOUR    = 3'd3;

   // source rotation of each of the ten steps in a half block
   function automatic logic [31:0] rot_step(input logic [31:0] w, input logic [3:0] sub);
      logic [31:0] r;
      r = w;
      case (sub)
         4'd0: r = {w[16:0], w[31:17]};
         4'd1: r = {w[6:0],  w[31:7]};
         4'd2: r = {w[22:0], w[31:23]};
         4'd3: r = {w[21:0], w[31:22]};
         4'd4: r = {w[14:0], w[31:15]};
         4'd5: r = {w[1:0],  w[31:2]};
         4'd6: r = {w[18:0], w[31:19]};
         4'd7: r = {w[11:0], w[31:12]};
         4'd8: r = {w[20:0], w[31:21]};
         4'd9: r = {w[26:0], w[31:27]};
         default: r = w;
      endcase
      return r;
   endfunction

   // steps that add into the destination, the others xor
   function automatic logic step_is_add(input logic [3:0] sub);
      logic a;
      case (sub) inside
         4'd0, 4'd1, 4'd4, 4'd7, 4'd8: a = 1'b1;
         default: a = 1'b0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

[sv/helix_stream_cipher_mac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// helix_stream_cipher_mac
// Helix stream cipher with MAC, one 32-bit message word per beat.
// ----------------------------------------------------------------------------
// Input beats (req_*) carry one little-endian message word, its byte count
// and a last flag. Result beats (rsp_*) carry the transformed word (if the
// byte count is nonzero) and, after a last beat, four MAC words.
// Key, key length, nonce and mode are written through the csr_* port while
// the core is idle; the user must keep to this, the core does not enforce
// it. Key, key length and mode are taken at the first beat of each message,
// the nonce when the key schedule ends. All block work goes through one
// step unit: one add/xor/rotate per cycle while stepping, steps 0 to
// STEP_LAST in each block; S_NEXT closes a block, S_PREP0 and S_PREP1 form
// the X words and S_EMIT emits where the block yields a result. The first
// beat of a message runs the key schedule (8 blocks) and 8 init blocks
// before its data block starts. A data word runs one data block; a last
// beat adds 8 blocks and 4 MAC blocks. req_ready is high only while idle.
// One output register holds a result; when the receiver stalls, the step
// unit waits at the emit point until that register is free.
// Reset clears the configuration registers, the cipher state and ends any
// message in flight.
// ----------------------------------------------------------------------------
module helix_stream_cipher_mac
   import hlx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_data_word,
   input  wire logic [2:0]  req_byte_count,
   input  wire logic        req_last_word,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_out_word,
   output logic [2:0]       rsp_out_bytes,
   output logic             rsp_is_tag,
   output logic             rsp_last_result,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   // configuration registers
   logic [63:0] key_ff [4];
   logic [5:0]  klen_ff;
   logic [63:0] nlo_ff, nhi_ff;
   logic        cmode_ff;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [31:0] r_ff [5];
   logic [31:0] r_in [5];
   logic [31:0] wk_ff [8];
   logic [31:0] wk_in [8];
   logic [31:0] ne_ff [8];
   logic [31:0] ne_in [8];
   logic [30:0] idxl_ff, idxl_in;
   logic [31:0] idxh_ff, idxh_in;
   logic        msg_ff, msg_in;
   logic [5:0]  len_ff, len_in;
   logic        mode_ff, mode_in;
   logic [4:0]  st_ff, st_in;
   logic [2:0]  blk_ff, blk_in;
   logic [31:0] x0_ff, x0_in, x1_ff, x1_in, p_ff, p_in;
   logic [31:0] data_ff, data_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        last_ff, last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic [2:0]  rsp_bytes_ff, rsp_bytes_in;
   logic        rsp_tag_ff, rsp_tag_in;
   logic        rsp_last_ff, rsp_last_in;

   // step unit signals
   logic [3:0]   sub;
   logic         round;
   logic [31:0]  src_op, res, rot;
   logic [255:0] key_all, key_mask;
   logic [5:0]   len_sat;
   logic [2:0]   wk_addr;
   logic [31:0]  wk_rd, x_extra, dmask, pv;
   logic         out_free;

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_word    = rsp_word_ff;
   assign rsp_out_bytes   = rsp_bytes_ff;
   assign rsp_is_tag      = rsp_tag_ff;
   assign rsp_last_result = rsp_last_ff;
   assign out_free        = !rsp_valid_ff || rsp_ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         klen_ff  <= '0;
         nlo_ff   <= '0;
         nhi_ff   <= '0;
         cmode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KEY01:  key_ff[0] <= csr_wdata;
            CSR_KEY23:  key_ff[1] <= csr_wdata;
            CSR_KEY45:  key_ff[2] <= csr_wdata;
            CSR_KEY67:  key_ff[3] <= csr_wdata;
            CSR_KEYLEN: klen_ff   <= csr_wdata[5:0];
            CSR_NONCEL: nlo_ff    <= csr_wdata;
            CSR_NONCEH: nhi_ff    <= csr_wdata;
            CSR_MODE:   cmode_ff  <= csr_wdata[0];
            default:    klen_ff   <= klen_ff;
         endcase
      end
   end

   // step unit: destination at slot 0, source at slot 3
   always_comb begin
      round  = (st_ff >= STEP_HALF);
      sub    = round ? 4'(st_ff - STEP_HALF) : st_ff[3:0];
      if (sub == 4'd5)
         src_op = r_ff[3] + (round ? x1_ff : x0_ff);
      else if (sub == 4'd0)
         src_op = r_ff[3] ^ (round ? p_ff : 32'd0);
      else
         src_op = r_ff[3];
      res = step_is_add(sub) ? (r_ff[0] + src_op) : (r_ff[0] ^ src_op);
      rot = rot_step(r_ff[3], sub);
   end

   // masked raw key
   always_comb begin
      key_all = {key_ff[3], key_ff[2], key_ff[1], key_ff[0]};
      len_sat = (klen_ff > KEY_LEN_MAX) ? KEY_LEN_MAX : klen_ff;
      for (int b = 0; b < 32; b++)
         key_mask[8*b +: 8] = (6'(b) < len_sat) ? key_all[8*b +: 8] : 8'h00;
   end

   // x word sources and data masking
   always_comb begin
      wk_addr = (state_ff == S_PREP1) ? (idxl_ff[2:0] + 3'd4) : idxl_ff[2:0];
      wk_rd   = wk_ff[wk_addr];
      if (idxl_ff[1:0] == 2'd3)
         x_extra = idxh_ff;
      else if (idxl_ff[1:0] == 2'd1)
         x_extra = {24'd0, len_ff, 2'b00};
      else
         x_extra = 32'd0;
      case (cnt_ff)
         3'd1:    dmask = 32'h0000_00ff;
         3'd2:    dmask = 32'h0000_ffff;
         3'd3:    dmask = 32'h00ff_ffff;
         default: dmask = 32'hffff_ffff;
      endcase
      pv = mode_ff ? ((data_ff ^ r_ff[0]) & dmask) : (data_ff & dmask);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = msg_ff ? S_WORD : S_KLOAD;
         S_KLOAD: state_in = S_RUN;
         S_RUN:   if (st_ff == STEP_LAST) state_in = S_NEXT;
         S_NEXT: begin
            unique case (phase_ff)
               PH_KEY:  state_in = (blk_ff == BLK_EIGHT) ? S_NLOAD : S_KLOAD;
               PH_INIT: state_in = (blk_ff == BLK_EIGHT) ? S_WORD : S_PREP0;
               PH_DATA: state_in = S_TAIL;
               PH_FIN:  state_in = S_PREP0;
               PH_TAG:  state_in = (blk_ff == BLK_FOUR) ? S_IDLE : S_PREP0;
               default: state_in = S_IDLE;
            endcase
         end
         S_NLOAD: state_in = S_PREP0;
         S_PREP0: state_in = S_PREP1;
         S_PREP1: state_in = (phase_ff == PH_DATA || phase_ff == PH_TAG) ? S_EMIT : S_RUN;
         S_EMIT:  if (out_free) state_in = S_RUN;
         S_WORD:  state_in = (cnt_ff != 3'd0) ? S_PREP0 : S_TAIL;
         S_TAIL:  state_in = last_ff ? S_PREP0 : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in = phase_ff;
      for (int i = 0; i < 5; i++) r_in[i] = r_ff[i];
      for (int i = 0; i < 8; i++) begin
         wk_in[i] = wk_ff[i];
         ne_in[i] = ne_ff[i];
      end
      idxl_in      = idxl_ff;
      idxh_in      = idxh_ff;
      msg_in       = msg_ff;
      len_in       = len_ff;
      mode_in      = mode_ff;
      st_in        = st_ff;
      blk_in       = blk_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      p_in         = p_ff;
      data_in      = data_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         // take a beat; a new message loads the masked key words
         S_IDLE: begin
            if (req_valid) begin
               data_in = req_data_word;
               cnt_in  = (req_byte_count > 3'd4) ? 3'd4 : req_byte_count;
               last_in = req_last_word;
               if (!msg_ff) begin
                  msg_in   = 1'b1;
                  len_in   = len_sat;
                  mode_in  = cmode_ff;
                  phase_in = PH_KEY;
                  blk_in   = 3'd0;
                  for (int i = 0; i < 8; i++) wk_in[i] = key_mask[32*i +: 32];
               end
            end
         end
         // key schedule block input
         S_KLOAD: begin
            for (int i = 0; i < 4; i++) r_in[i] = wk_ff[i];
            r_in[4] = 32'(len_ff) + KEY_E_BIAS;
            x0_in   = 32'd0;
            x1_in   = 32'd0;
            p_in    = 32'd0;
            st_in   = 5'd0;
         end
         // one step, then turn the register ring by one
         S_RUN: begin
            r_in[0] = r_ff[1];
            r_in[1] = r_ff[2];
            r_in[2] = rot;
            r_in[3] = r_ff[4];
            r_in[4] = res;
            st_in   = st_ff + 5'd1;
         end
         // block finished
         S_NEXT: begin
            blk_in = blk_ff + 3'd1;
            if (phase_ff == PH_KEY) begin
               for (int i = 0; i < 4; i++) begin
                  wk_in[i]     = r_ff[i] ^ wk_ff[i + 4];
                  wk_in[i + 4] = wk_ff[i];
               end
            end else begin
               idxl_in = idxl_ff + 31'd1;
               if (idxl_in == 31'd0) idxh_in = idxh_ff + 32'd1;
               if (phase_ff == PH_FIN && blk_ff == BLK_EIGHT) begin
                  phase_in = PH_TAG;
                  blk_in   = 3'd0;
               end
               if (phase_ff == PH_TAG && blk_ff == BLK_FOUR) msg_in = 1'b0;
            end
         end
         // nonce expansion and state load
         S_NLOAD: begin
            ne_in[0] = nlo_ff[31:0];
            ne_in[1] = nlo_ff[63:32];
            ne_in[2] = nhi_ff[31:0];
            ne_in[3] = nhi_ff[63:32];
            for (int i = 0; i < 4; i++) ne_in[i + 4] = 32'(i) - ne_in[i];
            r_in[0]  = wk_ff[3] ^ ne_in[0];
            r_in[1]  = wk_ff[4] ^ ne_in[1];
            r_in[2]  = wk_ff[5] ^ ne_in[2];
            r_in[3]  = wk_ff[6] ^ ne_in[3];
            r_in[4]  = wk_ff[7];
            idxl_in  = 31'd0;
            idxh_in  = 32'd0;
            phase_in = PH_INIT;
            blk_in   = 3'd0;
            p_in     = 32'd0;
         end
         // x words, first half
         S_PREP0: begin
            x0_in = wk_rd;
            x1_in = ne_ff[idxl_ff[2:0]] + {1'b0, idxl_ff} + x_extra;
            st_in = 5'd0;
         end
         S_PREP1: x1_in = x1_ff + wk_rd;
         // result beat goes to the output register
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (phase_ff == PH_DATA) begin
                  p_in         = pv;
                  rsp_word_in  = mode_ff ? pv : ((pv ^ r_ff[0]) & dmask);
                  rsp_bytes_in = cnt_ff;
                  rsp_tag_in   = 1'b0;
                  rsp_last_in  = 1'b0;
               end else begin
                  rsp_word_in  = r_ff[0];
                  rsp_bytes_in = 3'd4;
                  rsp_tag_in   = 1'b1;
                  rsp_last_in  = (blk_ff == BLK_FOUR);
               end
            end
         end
         S_WORD: if (cnt_ff != 3'd0) phase_in = PH_DATA;
         // mac start
         S_TAIL: begin
            if (last_ff) begin
               r_in[0]  = r_ff[0] ^ MAC_TWEAK;
               phase_in = PH_FIN;
               blk_in   = 3'd0;
               p_in     = {30'd0, cnt_ff[1:0]};
            end
         end
         default: phase_in = phase_ff;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_KEY;
         msg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= '0;
         blk_ff       <= '0;
         idxl_ff      <= '0;
         idxh_ff      <= '0;
         len_ff       <= '0;
         mode_ff      <= 1'b0;
         for (int i = 0; i < 5; i++) r_ff[i] <= '0;
         for (int i = 0; i < 8; i++) begin
            wk_ff[i] <= '0;
            ne_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         msg_ff       <= msg_in;
         rsp_valid_ff <= rsp_valid_in;
         st_ff        <= st_in;
         blk_ff       <= blk_in;
         idxl_ff      <= idxl_in;
         idxh_ff      <= idxh_in;
         len_ff       <= len_in;
         mode_ff      <= mode_in;
         for (int i = 0; i < 5; i++) r_ff[i] <= r_in[i];
         for (int i = 0; i < 8; i++) begin
            wk_ff[i] <= wk_in[i];
            ne_ff[i] <= ne_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x0_ff        <= x0_in;
      x1_ff        <= x1_in;
      p_ff         <= p_in;
      data_ff      <= data_in;
      cnt_ff       <= cnt_in;
      last_ff      <= last_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_last_ff  <= rsp_last_in;
   end

`ifndef SYNTH
   // emit point always fills a free output register
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free) |=> rsp_valid_ff)
      else $error("emit did not load output");

   // last marker only on mac words
   a_last_is_tag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> rsp_tag_ff)
      else $error("last result on non-tag word");

   // a block always ends after its final step
   a_block_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN && st_ff == STEP_LAST) |=> state_ff == S_NEXT)
      else $error("block did not finish");

   // step counter stays in range while stepping
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (st_ff <= STEP_LAST))
      else $error("step counter out of range");
`endif

endmodule
`default_nettype wire
